[src/column_line_crossing_detector_defines.svh]
// Assertion macros shared by the checker of column_line_crossing_detector.
// Expects i_clk and i_rst_n to be visible where a macro is used.
`ifndef COLUMN_LINE_CROSSING_DETECTOR_DEFINES_SVH
`define COLUMN_LINE_CROSSING_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLCD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clcd check failed");

// Next-cycle implication, checked outside reset.
`define CLCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clcd check failed");

`endif

[src/clcd_pkg.sv]
// Constants and command codes for the column line crossing detector.
// No dependencies; used by the top level and its checker.
package clcd_pkg;

    localparam int unsigned COLUMNS   = 64;
    localparam int unsigned COL_W     = $clog2(COLUMNS);
    localparam int unsigned CNT_W     = $clog2(COLUMNS + 1);
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned QC_W      = 7;
    // Largest dividend: |area end - region x| (at most 8190) times COLUMNS
    localparam int unsigned DIV_W     = $clog2(8190 * COLUMNS + 1);
    localparam int unsigned STEP_W    = $clog2(DIV_W);
    localparam int unsigned THRESHOLD = COLUMNS * 2 / 3;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_AREA  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

endpackage

[src/column_line_crossing_detector.sv]
// Column line crossing detector: per-colour seen-ever / seen-now column maps.
// Depends on clcd_pkg.
//
// Operation: a start-frame item is handled as it is accepted. A colored-area
// item runs DIV_W steps of a bit-serial restoring divider that scales both
// edges at once, then one sweep over the columns, one per cycle. A query runs
// the counting sweep and then loads the result register, which waits while an
// earlier result is still untaken. An area item while the region width is
// zero, and command code 3, are handled as they are accepted and change
// nothing. One item is worked on at a time; the input side is ready only
// while the block is idle.
module column_line_crossing_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_x,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_y,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_width,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_height,
    input  logic                         i_color,
    input  logic [clcd_pkg::COORD_W-1:0] i_area_x,
    input  logic [clcd_pkg::COORD_W-1:0] i_area_width,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_line_detected,
    output logic [clcd_pkg::QC_W-1:0]    o_qualifying_columns
);
    import clcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SWEEP,
        S_PUSH
    } t_state;

    t_state               r_state;
    logic [COLUMNS-1:0]   r_ever [2];
    logic [COLUMNS-1:0]   r_now  [2];
    logic [COORD_W-1:0]   r_reg_x;
    logic [COORD_W-1:0]   r_reg_y;
    logic [COORD_W-1:0]   r_reg_w;
    logic [COORD_W-1:0]   r_reg_h;
    logic                 r_any_frame;
    logic                 r_color;
    logic                 r_is_area;
    logic                 r_lo_neg;
    logic                 r_hi_neg;
    logic [DIV_W-1:0]     r_q_lo;
    logic [DIV_W-1:0]     r_q_hi;
    logic [COORD_W-1:0]   r_rem_lo;
    logic [COORD_W-1:0]   r_rem_hi;
    logic [STEP_W-1:0]    r_step;
    logic [COL_W-1:0]     r_col;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic                 r_line_det;
    logic [QC_W-1:0]      r_qual;

    // Edge offsets relative to the stored region
    logic [COORD_W:0]     w_lo;
    logic [COORD_W+1:0]   w_hi;
    logic                 w_hi_neg;
    logic [COORD_W+1:0]   w_hi_abs;
    logic [DIV_W-1:0]     w_lo_dvd;
    logic [DIV_W-1:0]     w_hi_dvd;
    logic                 w_region_diff;

    // Divider step
    logic [COORD_W:0]     w_lo_try;
    logic [COORD_W:0]     w_hi_try;
    logic [COORD_W:0]     w_lo_sub;
    logic [COORD_W:0]     w_hi_sub;
    logic                 w_lo_ge;
    logic                 w_hi_ge;

    // Column sweep
    logic                 w_lo_big;
    logic                 w_hi_out;
    logic                 w_hi_sat;
    logic [COL_W-1:0]     w_first;
    logic [COL_W-1:0]     w_last;
    logic                 w_in_run;
    logic                 w_mark;
    logic [COLUMNS-1:0]   w_ever_sel;
    logic [COLUMNS-1:0]   w_now_sel;
    logic                 w_qual_bit;
    logic [CNT_W+QC_W-1:0] w_cnt_ext;

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_line_detected      = r_line_det;
    assign o_qualifying_columns = r_qual;

    assign w_lo     = {1'b0, i_area_x} - {1'b0, r_reg_x};
    assign w_hi     = {w_lo[COORD_W], w_lo} + {2'b00, i_area_width};
    assign w_hi_neg = w_hi[COORD_W+1];
    assign w_hi_abs = w_hi_neg ? (~w_hi + 1'b1) : w_hi;
    assign w_lo_dvd = DIV_W'(w_lo[COORD_W-1:0]) * DIV_W'(COLUMNS);
    assign w_hi_dvd = DIV_W'(w_hi_abs) * DIV_W'(COLUMNS);

    assign w_region_diff = (i_region_x != r_reg_x) || (i_region_y != r_reg_y) ||
                           (i_region_width != r_reg_w) || (i_region_height != r_reg_h);

    assign w_lo_try = {r_rem_lo, r_q_lo[DIV_W-1]};
    assign w_hi_try = {r_rem_hi, r_q_hi[DIV_W-1]};
    assign w_lo_ge  = (w_lo_try >= {1'b0, r_reg_w});
    assign w_hi_ge  = (w_hi_try >= {1'b0, r_reg_w});
    assign w_lo_sub = w_lo_try - {1'b0, r_reg_w};
    assign w_hi_sub = w_hi_try - {1'b0, r_reg_w};

    // A negative start clamps to column 0; a negative end truncates to 0 only
    // when its magnitude quotient is zero, otherwise the run is empty.
    assign w_lo_big = !r_lo_neg && (r_q_lo >= DIV_W'(COLUMNS));
    assign w_hi_out = r_hi_neg && (r_q_hi != '0);
    assign w_hi_sat = r_q_hi >= DIV_W'(COLUMNS - 1);
    assign w_first  = r_lo_neg ? '0 : r_q_lo[COL_W-1:0];
    assign w_last   = r_hi_neg ? '0 :
                      (w_hi_sat ? COL_W'(COLUMNS - 1) : r_q_hi[COL_W-1:0]);
    assign w_in_run = !w_lo_big && !w_hi_out && (r_col >= w_first) && (r_col <= w_last);
    assign w_mark   = r_is_area && w_in_run;

    assign w_ever_sel = r_ever[r_color];
    assign w_now_sel  = r_now[r_color];
    assign w_qual_bit = w_ever_sel[0] && !w_now_sel[0];
    assign w_cnt_ext  = {{QC_W{1'b0}}, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ever      <= '{default: '0};
            r_now       <= '{default: '0};
            r_reg_x     <= '0;
            r_reg_y     <= '0;
            r_reg_w     <= '0;
            r_reg_h     <= '0;
            r_any_frame <= 1'b0;
        end else begin
            // drop a taken result unless the push below loads the next one
            if (r_out_valid && i_out_ready && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_command)
                            CMD_FRAME: begin
                                if (w_region_diff) begin
                                    r_ever <= '{default: '0};
                                end
                                r_now       <= '{default: '0};
                                r_reg_x     <= i_region_x;
                                r_reg_y     <= i_region_y;
                                r_reg_w     <= i_region_width;
                                r_reg_h     <= i_region_height;
                                r_any_frame <= 1'b1;
                            end
                            CMD_AREA: begin
                                // drop areas while the region has no width
                                if (r_reg_w != '0) begin
                                    r_color   <= i_color;
                                    r_is_area <= 1'b1;
                                    r_lo_neg  <= w_lo[COORD_W];
                                    r_hi_neg  <= w_hi_neg;
                                    r_q_lo    <= w_lo_dvd;
                                    r_q_hi    <= w_hi_dvd;
                                    r_rem_lo  <= '0;
                                    r_rem_hi  <= '0;
                                    r_step    <= '0;
                                    r_state   <= S_DIV;
                                end
                            end
                            CMD_QUERY: begin
                                r_color   <= i_color;
                                r_is_area <= 1'b0;
                                r_col     <= '0;
                                r_cnt     <= '0;
                                r_state   <= S_SWEEP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem_lo <= w_lo_ge ? w_lo_sub[COORD_W-1:0] : w_lo_try[COORD_W-1:0];
                    r_rem_hi <= w_hi_ge ? w_hi_sub[COORD_W-1:0] : w_hi_try[COORD_W-1:0];
                    r_q_lo   <= {r_q_lo[DIV_W-2:0], w_lo_ge};
                    r_q_hi   <= {r_q_hi[DIV_W-2:0], w_hi_ge};
                    r_step   <= STEP_W'(r_step + 1'b1);
                    if (r_step == STEP_W'(DIV_W - 1)) begin
                        r_col   <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    // rotate the selected colour's maps so column r_col sits at bit 0
                    r_ever[r_color] <= {w_ever_sel[0] | w_mark, w_ever_sel[COLUMNS-1:1]};
                    r_now[r_color]  <= {w_now_sel[0] | w_mark, w_now_sel[COLUMNS-1:1]};
                    if (!r_is_area) begin
                        r_cnt <= CNT_W'(r_cnt + CNT_W'(w_qual_bit));
                    end
                    r_col <= COL_W'(r_col + 1'b1);
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        r_state <= r_is_area ? S_IDLE : S_PUSH;
                    end
                end
                S_PUSH: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_line_det  <= r_any_frame && (r_cnt > CNT_W'(THRESHOLD));
                        r_qual      <= w_cnt_ext[QC_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/clcd_checker.sv]
// Port-level checks for column_line_crossing_detector, bound to the top level.
// Depends on clcd_pkg and column_line_crossing_detector_defines.svh.
`include "column_line_crossing_detector_defines.svh"

module clcd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_command,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_line_detected,
    input logic [clcd_pkg::QC_W-1:0]    o_qualifying_columns
);
    import clcd_pkg::*;

    logic            w_in_xfer;
    logic            w_out_stall;
    logic            w_det_shown;
    logic            w_count_high;
    logic [QC_W:0]   w_result;

    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign w_out_stall  = o_out_valid && !i_out_ready;
    assign w_det_shown  = o_out_valid && o_line_detected;
    assign w_count_high = (CNT_W > QC_W) || (o_qualifying_columns > QC_W'(THRESHOLD));
    assign w_result     = {o_line_detected, o_qualifying_columns};

    // A stalled result holds
    `CLCD_ASSERT_NEXT(a_out_hold, w_out_stall, o_out_valid && $stable(w_result))
    // Detection only with a count above two thirds of the columns
    `CLCD_ASSERT_IMPL(a_det_count, w_det_shown, w_count_high)
    // A query keeps the block busy for its sweep
    `CLCD_ASSERT_NEXT(a_query_busy, w_in_xfer && (i_command == CMD_QUERY), !o_in_ready)
    // A frame start leaves the input side ready in the next cycle
    `CLCD_ASSERT_NEXT(a_frame_quick, w_in_xfer && (i_command == CMD_FRAME), o_in_ready)

endmodule

bind column_line_crossing_detector clcd_checker u_clcd_checker (.*);

[test/column_line_crossing_detector_checker.sv]
`timescale 1ns / 1ps
// Checker for column_line_crossing_detector: watches both transfer channels, keeps its own
// copy of the per-colour column maps and compares every query answer. Depends on clcd_pkg.
module column_line_crossing_detector_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_x,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_y,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_width,
    input  logic [clcd_pkg::COORD_W-1:0] i_region_height,
    input  logic                         i_color,
    input  logic [clcd_pkg::COORD_W-1:0] i_area_x,
    input  logic [clcd_pkg::COORD_W-1:0] i_area_width,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_line_detected,
    input  logic [clcd_pkg::QC_W-1:0]    i_qualifying_columns,
    output int                           o_errors,
    output int                           o_pending
);
    import clcd_pkg::*;

    localparam int NCOL         = COLUMNS;
    localparam int VERDICT_SLOTS = 16;

    typedef struct {
        logic            detected;
        logic [QC_W-1:0] columns;
    } t_verdict;

    logic [COLUMNS-1:0] ever_map [2];
    logic [COLUMNS-1:0] now_map  [2];
    logic [COORD_W-1:0] region_x, region_y, region_w, region_h;
    logic               frame_seen;
    t_verdict           verdict_ring [VERDICT_SLOTS];
    int                 ring_wr;
    int                 ring_rd;
    int                 ring_used;
    int                 mismatch_cnt;

    // Advance the column maps by one accepted item; queue an answer for a query.
    task automatic update_column_maps();
        int       lo, hi, first, last, count;
        t_verdict v;
        case (i_command)
            CMD_FRAME: begin
                if (i_region_x != region_x || i_region_y != region_y ||
                    i_region_width != region_w || i_region_height != region_h) begin
                    ever_map[0] = '0;
                    ever_map[1] = '0;
                end
                region_x   = i_region_x;
                region_y   = i_region_y;
                region_w   = i_region_width;
                region_h   = i_region_height;
                now_map[0] = '0;
                now_map[1] = '0;
                frame_seen = 1'b1;
            end
            CMD_AREA: begin
                if (region_w != '0) begin
                    lo    = int'(i_area_x) - int'(region_x);
                    hi    = lo + int'(i_area_width);
                    // int division truncates towards zero, as the block does
                    first = (lo * NCOL) / int'(region_w);
                    last  = (hi * NCOL) / int'(region_w);
                    if (first < 0) first = 0;
                    if (last > NCOL - 1) last = NCOL - 1;
                    for (int c = first; c <= last; c++) begin
                        ever_map[i_color][c] = 1'b1;
                        now_map[i_color][c]  = 1'b1;
                    end
                end
            end
            CMD_QUERY: begin
                count      = $countones(ever_map[i_color] & ~now_map[i_color]);
                v.detected = frame_seen && (count > THRESHOLD);
                v.columns  = count[QC_W-1:0];
                verdict_ring[ring_wr] = v;
                ring_wr    = (ring_wr + 1) % VERDICT_SLOTS;
                ring_used++;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ever_map[0]  = '0;
            ever_map[1]  = '0;
            now_map[0]   = '0;
            now_map[1]   = '0;
            region_x     = '0;
            region_y     = '0;
            region_w     = '0;
            region_h     = '0;
            frame_seen   = 1'b0;
            ring_wr      = 0;
            ring_rd      = 0;
            ring_used    = 0;
            mismatch_cnt = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (ring_used == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: det=%0d cols=%0d",
                                 i_line_detected, i_qualifying_columns);
                end else begin
                    t_verdict v;
                    v         = verdict_ring[ring_rd];
                    ring_rd   = (ring_rd + 1) % VERDICT_SLOTS;
                    ring_used--;
                    if (v.detected !== i_line_detected ||
                        v.columns !== i_qualifying_columns) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"query mismatch: expected det=%0d cols=%0d, ",
                                      "got det=%0d cols=%0d"},
                                     v.detected, v.columns, i_line_detected,
                                     i_qualifying_columns);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                update_column_maps();
        end
        o_errors  <= mismatch_cnt;
        o_pending <= ring_used;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the column_line_crossing_detector test: clock, reset, stimulus and verdict.
// Depends on clcd_pkg, the block and column_line_crossing_detector_checker.
module testbench;
    import clcd_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         PHASE_ITEMS = 325;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         DRAIN_CYCLES = 120;

    typedef struct {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] rx, ry, rw, rh;
        logic               color;
        logic [COORD_W-1:0] ax, aw;
    } t_item;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_command;
    logic [COORD_W-1:0] i_region_x, i_region_y, i_region_width, i_region_height;
    logic               i_color;
    logic [COORD_W-1:0] i_area_x, i_area_width;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_line_detected;
    logic [QC_W-1:0]    o_qualifying_columns;

    int                 error_cnt;
    int                 pending_cnt;
    int                 cycle_cnt;
    int                 idle_pct;
    int                 stall_pct;
    int                 counted_items;
    logic [COORD_W-1:0] sent_rw;
    logic [COORD_W-1:0] cur_rx, cur_ry, cur_rw, cur_rh;

    column_line_crossing_detector DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_region_x          (i_region_x),
        .i_region_y          (i_region_y),
        .i_region_width      (i_region_width),
        .i_region_height     (i_region_height),
        .i_color             (i_color),
        .i_area_x            (i_area_x),
        .i_area_width        (i_area_width),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_line_detected     (o_line_detected),
        .o_qualifying_columns(o_qualifying_columns)
    );

    column_line_crossing_detector_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_region_x          (i_region_x),
        .i_region_y          (i_region_y),
        .i_region_width      (i_region_width),
        .i_region_height     (i_region_height),
        .i_color             (i_color),
        .i_area_x            (i_area_x),
        .i_area_width        (i_area_width),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_line_detected     (o_line_detected),
        .i_qualifying_columns(o_qualifying_columns),
        .o_errors            (error_cnt),
        .o_pending           (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: stall at random at the current rate.
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    function automatic t_item random_item();
        t_item it;
        it.cmd   = 2'($urandom_range(0, 3));
        it.rx    = COORD_W'($urandom);
        it.ry    = COORD_W'($urandom);
        it.rw    = COORD_W'($urandom);
        it.rh    = COORD_W'($urandom);
        it.color = 1'($urandom);
        it.ax    = COORD_W'($urandom);
        it.aw    = COORD_W'($urandom);
        return it;
    endfunction

    // Hold valid across back-to-back items; drop it only for an idle gap.
    task automatic send_item(input t_item it);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_command       <= it.cmd;
        i_region_x      <= it.rx;
        i_region_y      <= it.ry;
        i_region_width  <= it.rw;
        i_region_height <= it.rh;
        i_color         <= it.color;
        i_area_x        <= it.ax;
        i_area_width    <= it.aw;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.cmd == CMD_FRAME)
            sent_rw = it.rw;
        if (it.cmd != CMD_UNUSED && !(it.cmd == CMD_AREA && sent_rw == '0))
            counted_items++;
    endtask

    task automatic send_fields(input logic [1:0] cmd, input int rx, input int ry,
                               input int rw, input int rh, input logic color,
                               input int ax, input int aw);
        t_item it;
        it.cmd   = cmd;
        it.rx    = COORD_W'(rx);
        it.ry    = COORD_W'(ry);
        it.rw    = COORD_W'(rw);
        it.rh    = COORD_W'(rh);
        it.color = color;
        it.ax    = COORD_W'(ax);
        it.aw    = COORD_W'(aw);
        send_item(it);
    endtask

    task automatic send_query();
        t_item it;
        it     = random_item();
        it.cmd = CMD_QUERY;
        send_item(it);
    endtask

    // One frame: maybe move the region, then a few areas and queries, now and then noise.
    task automatic run_frame_burst();
        t_item it;
        int    span;
        int    pos;
        int    sel;
        if ($urandom_range(99) < 15) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: cur_ry = COORD_W'($urandom);
                1: cur_rh = COORD_W'($urandom);
                2: cur_rw = '0;
                3: cur_rw = COORD_W'($urandom_range(1, 64));
                4: cur_rw = '1;
                default: begin
                    cur_rx = COORD_W'($urandom);
                    cur_ry = COORD_W'($urandom);
                    cur_rw = COORD_W'($urandom_range(1, 4095));
                    cur_rh = COORD_W'($urandom);
                end
            endcase
        end
        it     = random_item();
        it.cmd = CMD_FRAME;
        it.rx  = cur_rx;
        it.ry  = cur_ry;
        it.rw  = cur_rw;
        it.rh  = cur_rh;
        send_item(it);

        span = (cur_rw == '0) ? 1 : int'(cur_rw);
        repeat ($urandom_range(0, 6)) begin
            it     = random_item();
            it.cmd = CMD_AREA;
            sel    = $urandom_range(99);
            if (sel < 80) begin
                // area mostly inside the region, sometimes hanging off its left edge
                pos = int'(cur_rx) + int'($urandom_range(0, span)) - int'($urandom_range(0, 16));
                if (pos < 0) pos = 0;
                if (pos > 4095) pos = 4095;
                it.ax = COORD_W'(pos);
                it.aw = COORD_W'($urandom_range(0, span / 4));
            end else if (sel < 90) begin
                it.ax = cur_rx;
                it.aw = cur_rw;
            end
            send_item(it);
            if ($urandom_range(99) < 10)
                send_query();
        end
        repeat ($urandom_range(1, 2))
            send_query();
        if ($urandom_range(99) < 8)
            send_item(random_item());
    endtask

    initial begin
        int idle_in  [4];
        int stall_out[4];
        idle_in         = '{0, 49, 0, 27};
        stall_out       = '{0, 0, 49, 27};
        idle_pct        = 0;
        stall_pct       = 0;
        counted_items   = 0;
        sent_rw         = '0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_FRAME;
        i_region_x      <= '0;
        i_region_y      <= '0;
        i_region_width  <= '0;
        i_region_height <= '0;
        i_color         <= 1'b0;
        i_area_x        <= '0;
        i_area_width    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries before any frame, the unused code, zero-width region,
        // full and empty column runs, unchanged and changed regions.
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_QUERY,  4095, 4095, 4095, 4095, 1'b1, 4095, 4095);
        send_fields(CMD_UNUSED, 4095, 4095, 4095, 4095, 1'b1, 4095, 4095);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b0, 10, 100);
        send_fields(CMD_FRAME,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b1, 0, 4095);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_FRAME,  100, 4095, 640, 4095, 1'b0, 0, 0);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b0, 100, 640);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b1, 0, 4095);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_FRAME,  100, 4095, 640, 4095, 1'b1, 4095, 4095);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b1, 0, 0);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b0, 4095, 4095);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b0, 420, 0);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_FRAME,  4095, 0, 4095, 0, 1'b0, 0, 0);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b0, 0, 0);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b1, 0, 0);
        send_fields(CMD_FRAME,  0, 0, 1, 1, 1'b0, 0, 0);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b1, 0, 0);
        send_fields(CMD_AREA,   0, 0, 0, 0, 1'b1, 4095, 4095);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b1, 0, 0);
        send_fields(CMD_FRAME,  0, 0, 1, 1, 1'b0, 0, 0);
        send_fields(CMD_QUERY,  0, 0, 0, 0, 1'b1, 0, 0);

        cur_rx = COORD_W'($urandom);
        cur_ry = COORD_W'($urandom);
        cur_rw = COORD_W'($urandom_range(1, 4095));
        cur_rh = COORD_W'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct      = idle_in[ph];
            stall_pct     = stall_out[ph];
            counted_items = 0;
            while (counted_items < PHASE_ITEMS)
                run_frame_burst();
        end
        i_in_valid <= 1'b0;
        idle_pct   = 0;

        // Let the last transfer reach the checker, then drain the answers.
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0 && pending_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
